// File: hw/rtl/ifq_pkg.sv
package ifq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ENTRY_WIDTH = 32;
  localparam int unsigned POS_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_READ   = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e              req_type;
    logic [ENTRY_WIDTH-1:0] entry_value;
    logic [POS_W-1:0]       position;
  } req_t;

  typedef struct packed {
    logic [ENTRY_WIDTH-1:0] entry_out;
    status_e                status;
    logic [CNT_W-1:0]       entry_count;
  } rsp_t;

  // per-cell control: load takes the pushed item, shift takes the neighbor
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/ifq_cell.sv
module ifq_cell (
  input  logic                           clk_i,
  input  ifq_pkg::cell_ctrl_t            ctrl_i,
  input  logic [ifq_pkg::ENTRY_WIDTH-1:0] push_data_i,
  input  logic [ifq_pkg::ENTRY_WIDTH-1:0] next_data_i,
  output logic [ifq_pkg::ENTRY_WIDTH-1:0] data_o
);
  import ifq_pkg::*;

  logic [ENTRY_WIDTH-1:0] data_q;
  logic [ENTRY_WIDTH-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = push_data_i;
    end else if (ctrl_i.shift) begin
      data_d = next_data_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: hw/rtl/indexed_fifo_queue_unit.sv
// Ordered queue of entry handles with push, pop, read at a position, remove at
// a position (the entries behind it close the gap) and clear. A request is
// taken at a rising edge with start high and busy low; busy never rises, so a
// request can be issued every cycle. Each request gives exactly one item on
// rsp_o in the next cycle, flagged by result_valid_o for a single cycle, and the
// receiver has no way to hold it. The queue lives in a row of DEPTH cells; the
// cells load the pushed item or shift from their neighbor together, so each
// request kind gets its answer in the next cycle. The entry, the status and
// the new count come back together. Misses (empty pop, position at or beyond
// the count, unknown request kinds) and a push onto a full queue report a
// status and return a zero entry without touching the queue.
module indexed_fifo_queue_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ifq_pkg::req_t req_i,
  output logic          result_valid_o,
  output ifq_pkg::rsp_t rsp_o
);
  import ifq_pkg::*;

  // ---------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------
  logic             accept;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             full;
  logic             pos_hit;
  logic             do_push;
  logic             do_take;
  logic [POS_W-1:0] take_pos;
  rsp_t             rsp_d;
  rsp_t             rsp_q;
  logic             valid_q;

  // cell row
  logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];
  cell_ctrl_t             cell_ctrl [DEPTH];
  logic [ENTRY_WIDTH-1:0] sel_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(DEPTH));
  // position compared against the count at full width
  assign pos_hit = ({{(CNT_W-POS_W){1'b0}}, req_i.position} < count_q);

  // pop is a remove at the head
  assign take_pos = (req_i.req_type == REQ_POP) ? '0 : req_i.position;
  assign sel_data = cell_data[take_pos];

  always_comb begin
    do_push           = 1'b0;
    do_take           = 1'b0;
    count_d           = count_q;
    rsp_d.entry_out   = '0;
    rsp_d.status      = ST_OK;
    unique case (req_i.req_type)
      REQ_PUSH: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          do_push = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      REQ_POP: begin
        if (count_q == '0) begin
          rsp_d.status = ST_MISS;
        end else begin
          do_take         = 1'b1;
          rsp_d.entry_out = sel_data;
          count_d         = count_q - CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (pos_hit) begin
          rsp_d.entry_out = sel_data;
        end else begin
          rsp_d.status = ST_MISS;
        end
      end
      REQ_REMOVE: begin
        if (pos_hit) begin
          do_take         = 1'b1;
          rsp_d.entry_out = sel_data;
          count_d         = count_q - CNT_W'(1);
        end else begin
          rsp_d.status = ST_MISS;
        end
      end
      REQ_CLEAR: begin
        count_d = '0;
      end
      default: begin
        rsp_d.status = ST_MISS;
      end
    endcase
    rsp_d.entry_count = count_d;
  end

  // ---------------------------------------------------------------------
  // cell row: push writes the cell at the tail, a take shifts every cell
  // from the taken position onward one place toward the head
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] next_data;

    always_comb begin
      cell_ctrl[i].load  = accept && do_push && (count_q == CNT_W'(i));
      cell_ctrl[i].shift = accept && do_take && (POS_W'(i) >= take_pos);
    end

    if (i == DEPTH - 1) begin : g_last
      // tail cell shifts in a blank, beyond the count anyway
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    ifq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .push_data_i (req_i.entry_value),
      .next_data_i (next_data),
      .data_o      (cell_data[i])
    );
  end

  // ---------------------------------------------------------------------
  // occupancy and result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

// File: hw/rtl/ifq_checker.sv
module ifq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          result_valid_o,
  input ifq_pkg::rsp_t rsp_o
);
  import ifq_pkg::*;

  // every accepted request gives an item in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("accepted request gave no result");

  // no item without a request in the cycle before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy))
    else $error("result without request");

  // count stays within the store
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rsp_o.entry_count <= CNT_W'(DEPTH)))
    else $error("count beyond depth");

  // a miss or a full push returns no entry
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status != ST_OK)) |-> (rsp_o.entry_out == '0))
    else $error("entry returned on miss or full");

  // full is reported only with the store full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status == ST_FULL)) |->
      (rsp_o.entry_count == CNT_W'(DEPTH)))
    else $error("full reported below depth");

endmodule

bind indexed_fifo_queue_unit ifq_checker u_ifq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

// File: bench/testbench.sv
module testbench;
  import ifq_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RANDOM_ITEMS = 1250;

  // request codes that the block does not know and must answer with a miss
  localparam logic [2:0] REQ_UNDEF_A = 3'd5;
  localparam logic [2:0] REQ_UNDEF_C = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic result_valid_o;
  rsp_t rsp_o;

  // one row of the directed plan: a request, how often to send it, and
  // optionally a hand-written response that replaces the predicted one
  typedef struct {
    req_t req;
    int   reps;
    bit   typed;
    rsp_t rsp;
  } plan_row_t;

  plan_row_t plan[$];

  // queue contents as the block should hold them, head at index 0
  logic [ENTRY_WIDTH-1:0] held_entries[$];
  // responses owed by the block, oldest first
  rsp_t owed_responses[$];

  // hand-written response that travels alongside the request being driven
  bit   row_typed;
  rsp_t row_rsp;

  int mismatch_count;

  indexed_fifo_queue_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // predicted response of one request; updates the held entries
  function automatic rsp_t compute_response(req_t r);
    rsp_t o;
    o.entry_out = '0;
    o.status    = ST_OK;
    case (r.req_type)
      REQ_PUSH: begin
        if (held_entries.size() >= DEPTH) o.status = ST_FULL;
        else held_entries.insert(held_entries.size(), r.entry_value);
      end
      REQ_POP: begin
        if (held_entries.size() == 0) begin
          o.status = ST_MISS;
        end else begin
          o.entry_out = held_entries[0];
          held_entries.delete(0);
        end
      end
      REQ_READ: begin
        if (r.position >= held_entries.size()) o.status = ST_MISS;
        else o.entry_out = held_entries[r.position];
      end
      REQ_REMOVE: begin
        // entries behind the removed one move one place toward the head
        if (r.position >= held_entries.size()) begin
          o.status = ST_MISS;
        end else begin
          o.entry_out = held_entries[r.position];
          held_entries.delete(r.position);
        end
      end
      REQ_CLEAR: held_entries.delete();
      default: o.status = ST_MISS;
    endcase
    o.entry_count = CNT_W'(held_entries.size());
    return o;
  endfunction

  function automatic req_t mk_req(logic [2:0] kind, logic [ENTRY_WIDTH-1:0] value,
                                  logic [POS_W-1:0] pos);
    req_t r;
    r.req_type    = req_type_e'(kind);
    r.entry_value = value;
    r.position    = pos;
    return r;
  endfunction

  function automatic plan_row_t mk_row(logic [2:0] kind, logic [ENTRY_WIDTH-1:0] value,
                                       logic [POS_W-1:0] pos, int reps, bit typed,
                                       logic [ENTRY_WIDTH-1:0] ent, status_e st,
                                       logic [CNT_W-1:0] cnt);
    plan_row_t p;
    p.req               = mk_req(kind, value, pos);
    p.reps              = reps;
    p.typed             = typed;
    p.rsp.entry_out     = ent;
    p.rsp.status        = st;
    p.rsp.entry_count   = cnt;
    return p;
  endfunction

  // append one row at the end of the directed plan
  function automatic void plan_add(plan_row_t p);
    plan.insert(plan.size(), p);
  endfunction

  // drive one item from a falling edge and hold it until it is taken
  task automatic send_item(input req_t r, input bit typed, input rsp_t want);
    start     <= 1'b1;
    req_i     <= r;
    row_typed <= typed;
    row_rsp   <= want;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic idle(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // response check first, then the prediction for an item taken at this edge
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (owed_responses.size() == 0) begin
          $display("%0t unexpected response: entry_out %h status %0d entry_count %0d",
                   $time, rsp_o.entry_out, rsp_o.status, rsp_o.entry_count);
          mismatch_count++;
        end else begin
          want = owed_responses[0];
          owed_responses.delete(0);
          if (rsp_o.entry_out !== want.entry_out) begin
            $display("%0t entry_out expected %h actual %h",
                     $time, want.entry_out, rsp_o.entry_out);
            mismatch_count++;
          end
          if (rsp_o.status !== want.status) begin
            $display("%0t status expected %0d actual %0d",
                     $time, want.status, rsp_o.status);
            mismatch_count++;
          end
          if (rsp_o.entry_count !== want.entry_count) begin
            $display("%0t entry_count expected %0d actual %0d",
                     $time, want.entry_count, rsp_o.entry_count);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        want = compute_response(req_i);
        if (row_typed) want = row_rsp;
        owed_responses.insert(owed_responses.size(), want);
      end
    end
  end

  initial begin
    #(CLK_PERIOD * 200000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    rsp_t   none;
    req_t   r;
    bit     grow;
    int     sent;
    int     burst;
    int     roll;
    int     count;
    int     wait_cycles;
    logic [2:0]             kind;
    logic [ENTRY_WIDTH-1:0] value;
    logic [POS_W-1:0]       pos;

    none           = '0;
    mismatch_count = 0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_i          = '0;
    row_typed      = 1'b0;
    row_rsp        = '0;

    // empty queue: every access misses, clear is harmless
    plan_add(mk_row(REQ_POP,     '0, '0,  1, 1, '0, ST_MISS, 0));
    plan_add(mk_row(REQ_REMOVE,  '0, '1,  1, 1, '0, ST_MISS, 0));
    plan_add(mk_row(REQ_UNDEF_C, '1, '1,  1, 1, '0, ST_MISS, 0));
    plan_add(mk_row(REQ_CLEAR,   '0, '0,  1, 1, '0, ST_OK,   0));
    // value extremes and reads around the count
    plan_add(mk_row(REQ_PUSH,    '1, '0,  1, 1, '0, ST_OK,   1));
    plan_add(mk_row(REQ_PUSH,    '0, '1,  1, 1, '0, ST_OK,   2));
    plan_add(mk_row(REQ_READ,    '0, '0,  1, 1, '1, ST_OK,   2));
    plan_add(mk_row(REQ_READ,    '0, 2,   1, 1, '0, ST_MISS, 2));
    // fill up, then a push onto a full queue is dropped
    plan_add(mk_row(REQ_PUSH, 32'h5555_5555, '0, 14, 0, '0, ST_OK, 0));
    plan_add(mk_row(REQ_PUSH, 32'haaaa_aaaa, '0, 1, 1, '0, ST_FULL, 16));
    plan_add(mk_row(REQ_READ,    '0, '1,  1, 1, 32'h5555_5555, ST_OK, 16));
    // remove the tail, the head and one in the middle
    plan_add(mk_row(REQ_REMOVE,  '0, '1,  1, 1, 32'h5555_5555, ST_OK, 15));
    plan_add(mk_row(REQ_REMOVE,  '0, '0,  1, 1, '1, ST_OK,   14));
    plan_add(mk_row(REQ_POP,     '1, '1,  1, 1, '0, ST_OK,   13));
    plan_add(mk_row(REQ_REMOVE,  '0, 7,   1, 0, '0, ST_OK,   0));
    plan_add(mk_row(REQ_CLEAR,   '1, '1,  1, 1, '0, ST_OK,   0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      repeat (plan[i].reps) send_item(plan[i].req, plan[i].typed, plan[i].rsp);
      if ($urandom_range(0, 2) == 0) idle(1);
    end

    // random part: grow and shrink phases so the queue swings between
    // empty and full, in bursts with gaps of random length
    grow = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        count = held_entries.size();
        if (count == DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
        if (count == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
        if ($urandom_range(0, 39) == 0) grow = !grow;

        roll = $urandom_range(0, 99);
        if (roll < 2) kind = $urandom_range(REQ_UNDEF_A, REQ_UNDEF_C);
        else if (roll < 3) kind = REQ_CLEAR;
        else if (roll < (grow ? 58 : 18)) kind = REQ_PUSH;
        else begin
          roll = $urandom_range(0, 9);
          if (roll < 4) kind = REQ_READ;
          else if (roll < 7) kind = REQ_POP;
          else kind = REQ_REMOVE;
        end

        // mostly positions that hit, sometimes any position
        if (count > 0 && $urandom_range(0, 9) < 8) pos = $urandom_range(0, count - 1);
        else pos = $urandom_range(0, DEPTH - 1);

        roll = $urandom_range(0, 19);
        if (roll == 0) value = '0;
        else if (roll == 1) value = '1;
        else value = $urandom;

        r = mk_req(kind, value, pos);
        send_item(r, 1'b0, none);
        sent++;
      end
      // some bursts run straight into the next one
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 5));
    end

    idle(0);
    wait_cycles = 0;
    while (owed_responses.size() != 0 && wait_cycles < 100) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (3) @(posedge clk_i);
    if (owed_responses.size() != 0) begin
      $display("%0t %0d responses never arrived", $time, owed_responses.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ifq_pkg.sv
hw/rtl/ifq_cell.sv
hw/rtl/indexed_fifo_queue_unit.sv
hw/rtl/ifq_checker.sv
bench/testbench.sv
